FILE: hw/rtl/indi_axis_rate_controller_unit_defines.svh
// Assertion helpers shared by the rate controller
`ifndef INDI_AXIS_RATE_CONTROLLER_UNIT_DEFINES_SVH
`define INDI_AXIS_RATE_CONTROLLER_UNIT_DEFINES_SVH

// antecedent and consequent in the same cycle
`define IRC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lbl violated");

// consequent in the cycle after the antecedent
`define IRC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbl violated");

`endif

FILE: hw/rtl/irc_pkg.sv
package irc_pkg;

   localparam int ERR_FRAC   = 15;
   localparam int RATE_FRAC  = 12;
   localparam int STEP_SHIFT = 9;
   localparam int THRUST_MIN = 300;

   localparam int ERR_W    = 16;
   localparam int RATE_W   = 21;
   localparam int THRUST_W = 14;
   localparam int CMD_W    = 15;
   localparam int GAIN_W   = 16;
   localparam int LIMIT_W  = 14;
   localparam int IDX_W    = 3;
   localparam int ST_W     = 40;
   localparam int ACC_W    = 64;
   localparam int MUL_CNT_W = $clog2(GAIN_W);

   localparam logic [GAIN_W-1:0] ACT_GAIN = 16'd1966;
   localparam int CMD_SAT = 9600;

   typedef logic signed [ST_W-1:0]  state_type;
   typedef logic signed [ACC_W-1:0] acc_type;

   typedef enum logic [IDX_W-1:0] {
      REG_PROP_GAIN   = 3'd0,
      REG_DAMP_GAIN   = 3'd1,
      REG_CTRL_EFF    = 3'd2,
      REG_FILT_DAMP   = 3'd3,
      REG_FILT_STIFF  = 3'd4,
      REG_CMD_LIMIT   = 3'd5,
      REG_THRUST_MODE = 3'd6,
      REG_LATE_CLAMP  = 3'd7
   } reg_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FA, ST_FB, ST_FC, ST_PA, ST_PB, ST_PC, ST_PD
   } seq_state_type;

   // saturate to the signed 40-bit state range
   function automatic state_type sat40(input acc_type v);
      acc_type hi;
      acc_type lo;
      hi = (acc_type'(1) <<< (ST_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return state_type'(hi);
      if (v < lo) return state_type'(lo);
      return state_type'(v);
   endfunction

   function automatic acc_type to_q16(input acc_type v, input int frac);
      if (frac <= 16) return v <<< (16 - frac);
      return v >>> (frac - 16);
   endfunction

   // truncate toward zero to an integer, then saturate
   function automatic logic signed [CMD_W-1:0] out_cmd(input acc_type v);
      acc_type mag;
      acc_type i;
      mag = (v < 0) ? -v : v;
      i = mag >>> 16;
      if (i > acc_type'(CMD_SAT)) i = acc_type'(CMD_SAT);
      if (v < 0) i = -i;
      return i[CMD_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/irc_req_if.sv
interface irc_req_if;
   import irc_pkg::*;
   logic valid;
   logic ready;
   logic signed [ERR_W-1:0]  att_error;
   logic signed [RATE_W-1:0] gyro_rate;
   logic [THRUST_W-1:0]      thrust;
   modport source (output valid, att_error, gyro_rate, thrust, input ready);
   modport sink (input valid, att_error, gyro_rate, thrust, output ready);
endinterface

FILE: hw/rtl/irc_rsp_if.sv
interface irc_rsp_if;
   import irc_pkg::*;
   logic valid;
   logic ready;
   logic signed [CMD_W-1:0] command;
   modport source (output valid, command, input ready);
   modport sink (input valid, command, output ready);
endinterface

FILE: hw/rtl/irc_csr_if.sv
interface irc_csr_if;
   import irc_pkg::*;
   logic valid;
   logic ready;
   logic [IDX_W-1:0]  index;
   logic [GAIN_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/irc_mul.sv
// bit-serial shift-add multiplier: signed multiplicand, unsigned 16-bit multiplier
module irc_mul (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  irc_pkg::acc_type           mcand,
   input  logic [irc_pkg::GAIN_W-1:0] mplier,
   output logic                       busy,
   output irc_pkg::acc_type           product
);
   import irc_pkg::*;

   acc_type a_ff, a_in, p_ff, p_in;
   logic [GAIN_W-1:0] b_ff, b_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      p_in = p_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         a_in = mcand;
         b_in = mplier;
         p_in = '0;
         cnt_in = MUL_CNT_W'(GAIN_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) p_in = p_ff + a_ff;
         a_in = a_ff <<< 1;
         b_in = b_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      p_ff <= p_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign busy = busy_ff;
   assign product = p_ff;
endmodule

FILE: hw/rtl/indi_axis_rate_controller_unit.sv
// One axis of an INDI attitude rate controller.
// req_chan carries one request per control tick: att_error (Q.15), gyro_rate
// (Q.12) and thrust. rsp_chan returns exactly one command per request, an
// integer saturated at +-9600. csr_chan writes the eight gain and mode
// registers by index; it is always ready and must be used only while idle.
// Each request is worked through by a sequencer around one bit-serial
// shift-add multiplier, one multiplier bit per cycle: eight multiplications
// plus two filter advances. A new request is accepted only once the
// sequencer is back in idle after all work on the previous one. The command
// is registered in the increment step; the remaining work (actuator model
// and command filter) overlaps with the wait for rsp_chan. The multiplier
// and any stall on rsp_chan set the latency.
// The command waits in an output register while rsp_chan stalls; the
// sequencer holds in the increment step before loading the next command
// while the previous one is still untaken, so a stall that lasts until the
// next request reaches the increment step delays that request.
// Synchronous reset clears all filter states, loads register defaults and
// leaves the block idle and ready for a request on the next cycle.
`include "indi_axis_rate_controller_unit_defines.svh"
module indi_axis_rate_controller_unit (
   input logic      clock,
   input logic      reset,
   irc_req_if.sink  req_chan,
   irc_rsp_if.source rsp_chan,
   irc_csr_if.sink  csr_chan
);
   import irc_pkg::*;

   // configuration
   logic [GAIN_W-1:0] prop_gain_ff, damp_gain_ff, ctrl_eff_ff, filt_damp_ff, filt_stiff_ff;
   logic [LIMIT_W-1:0] cmd_limit_ff;
   logic thrust_mode_ff, late_clamp_ff;

   // filter states: entry 0 body rate filter, entry 1 command filter
   state_type fx_ff [2];
   state_type fxd_ff [2];
   state_type fxdd_ff [2];
   state_type fx_in [2];
   state_type fxd_in [2];
   state_type fxdd_in [2];
   state_type act_ff, act_in;

   // per-request operands and scratch
   acc_type err_ff, err_in, rate_ff, rate_in, tmp_ff, tmp_in;
   logic [THRUST_W-1:0] thrust_ff, thrust_in;
   logic sel_ff, sel_in;
   seq_state_type state_ff, state_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [CMD_W-1:0] cmd_ff, cmd_in;

   // multiplier
   logic mul_start, mul_busy;
   acc_type mul_a, mul_p;
   logic [GAIN_W-1:0] mul_b;

   irc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_a),
      .mplier  (mul_b),
      .busy    (mul_busy),
      .product (mul_p)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.command = cmd_ff;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      state_type nx, nxd, acc, du;
      acc_type u, uc, bound, target;
      nx = '0;
      nxd = '0;
      acc = '0;
      du = '0;
      u = '0;
      uc = '0;
      bound = '0;
      target = '0;
      state_in = state_ff;
      fx_in = fx_ff;
      fxd_in = fxd_ff;
      fxdd_in = fxdd_ff;
      act_in = act_ff;
      err_in = err_ff;
      rate_in = rate_ff;
      tmp_in = tmp_ff;
      thrust_in = thrust_ff;
      sel_in = sel_ff;
      cmd_in = cmd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      mul_start = 1'b0;
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               err_in = to_q16(acc_type'(req_chan.att_error), ERR_FRAC);
               rate_in = to_q16(acc_type'(req_chan.gyro_rate), RATE_FRAC);
               thrust_in = req_chan.thrust;
               sel_in = 1'b0;
               state_in = ST_FA;
            end
         end
         ST_FA: begin
            // advance position and velocity, start the damping product
            nx = sat40(acc_type'(fx_ff[sel_ff]) + (acc_type'(fxd_ff[sel_ff]) >>> STEP_SHIFT));
            nxd = sat40(acc_type'(fxd_ff[sel_ff]) + (acc_type'(fxdd_ff[sel_ff]) >>> STEP_SHIFT));
            fx_in[sel_ff] = nx;
            fxd_in[sel_ff] = nxd;
            mul_start = 1'b1;
            mul_a = -acc_type'(nxd);
            mul_b = filt_damp_ff;
            state_in = ST_FB;
         end
         ST_FB: begin
            if (!mul_busy) begin
               target = sel_ff ? acc_type'(act_ff) : rate_ff;
               tmp_in = mul_p >>> 8;
               mul_start = 1'b1;
               mul_a = target - acc_type'(fx_ff[sel_ff]);
               mul_b = filt_stiff_ff;
               state_in = ST_FC;
            end
         end
         ST_FC: begin
            if (!mul_busy) begin
               fxdd_in[sel_ff] = sat40(tmp_ff + mul_p);
               if (!sel_ff) begin
                  mul_start = 1'b1;
                  mul_a = err_ff;
                  mul_b = prop_gain_ff;
                  state_in = ST_PA;
               end else begin
                  // low thrust: drop the command path history
                  if (thrust_ff < THRUST_W'(THRUST_MIN)) begin
                     act_in = '0;
                     fx_in[1] = '0;
                     fxd_in[1] = '0;
                     fxdd_in[1] = '0;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PA: begin
            if (!mul_busy) begin
               tmp_in = mul_p;
               mul_start = 1'b1;
               mul_a = acc_type'(fx_ff[0]);
               mul_b = damp_gain_ff;
               state_in = ST_PB;
            end
         end
         ST_PB: begin
            if (!mul_busy) begin
               acc = sat40((tmp_ff - mul_p) >>> 8);
               mul_start = 1'b1;
               mul_a = acc_type'(acc) - acc_type'(fxd_ff[0]);
               mul_b = ctrl_eff_ff;
               state_in = ST_PC;
            end
         end
         ST_PC: begin
            if (!mul_busy && (!rsp_valid_ff || rsp_chan.ready)) begin
               du = sat40(mul_p >>> 8);
               u = acc_type'(fx_ff[1]) + acc_type'(du);
               bound = thrust_mode_ff ? (acc_type'(thrust_ff) <<< 15)
                                      : (acc_type'(cmd_limit_ff) <<< 16);
               uc = u;
               if (uc > bound) uc = bound;
               if (uc < -bound) uc = -bound;
               cmd_in = out_cmd(late_clamp_ff ? u : uc);
               rsp_valid_in = 1'b1;
               mul_start = 1'b1;
               mul_a = uc - acc_type'(act_ff);
               mul_b = ACT_GAIN;
               state_in = ST_PD;
            end
         end
         ST_PD: begin
            if (!mul_busy) begin
               act_in = sat40(acc_type'(act_ff) + (mul_p >>> 16));
               sel_in = 1'b1;
               state_in = ST_FA;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sel_ff <= 1'b0;
         act_ff <= '0;
         for (int i = 0; i < 2; i++) begin
            fx_ff[i] <= '0;
            fxd_ff[i] <= '0;
            fxdd_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sel_ff <= sel_in;
         act_ff <= act_in;
         fx_ff <= fx_in;
         fxd_ff <= fxd_in;
         fxdd_ff <= fxdd_in;
      end
      err_ff <= err_in;
      rate_ff <= rate_in;
      tmp_ff <= tmp_in;
      thrust_ff <= thrust_in;
      cmd_ff <= cmd_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff <= 16'd24320;
         damp_gain_ff <= 16'd2560;
         ctrl_eff_ff <= 16'd10240;
         filt_damp_ff <= 16'd9472;
         filt_stiff_ff <= 16'd2500;
         cmd_limit_ff <= 14'd4500;
         thrust_mode_ff <= 1'b0;
         late_clamp_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         case (reg_idx_type'(csr_chan.index))
            REG_PROP_GAIN:   prop_gain_ff <= csr_chan.data;
            REG_DAMP_GAIN:   damp_gain_ff <= csr_chan.data;
            REG_CTRL_EFF:    ctrl_eff_ff <= csr_chan.data;
            REG_FILT_DAMP:   filt_damp_ff <= csr_chan.data;
            REG_FILT_STIFF:  filt_stiff_ff <= csr_chan.data;
            REG_CMD_LIMIT:   cmd_limit_ff <= csr_chan.data[LIMIT_W-1:0];
            REG_THRUST_MODE: thrust_mode_ff <= csr_chan.data[0];
            REG_LATE_CLAMP:  late_clamp_ff <= csr_chan.data[0];
            default: ;
         endcase
      end
   end

   // an accepted request always starts the rate filter step
   `IRC_ASSERT_NEXT(a_req_starts, clock, reset, req_chan.valid && req_chan.ready, state_ff == ST_FA)
   // a command is only raised out of the increment step
   `IRC_ASSERT_SAME(a_rsp_from_pc, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_PC)
   // the multiplier never runs while the sequencer is idle
   `IRC_ASSERT_SAME(a_mul_idle, clock, reset, mul_busy, state_ff != ST_IDLE)

endmodule
